[rtl/core/fpba_pkg.sv]
`timescale 1ns / 1ps
// package for the fit policy block allocator: payload structs, codes and
// controller/datapath command and status types; no dependencies
package fpba_pkg;

	// fixed field widths
	localparam int SIZE_BITS      = 16;
	localparam int INDEX_BITS     = 6;
	localparam int DEF_MAX_BLOCKS = 64;

	// configuration port
	localparam int CFG_INDEX_BITS = 1;
	localparam int CFG_DATA_BITS  = 7;
	localparam logic [CFG_INDEX_BITS-1:0] REG_FIT_POLICY  = 1'b0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_BLOCK_COUNT = 1'b1;
	localparam logic [6:0] BLOCK_COUNT_RESET = 7'd64;

	// item function codes
	localparam logic [1:0] FUNC_LOAD  = 2'd0;
	localparam logic [1:0] FUNC_CLEAR = 2'd1;
	localparam logic [1:0] FUNC_ALLOC = 2'd2;

	// fit policy codes
	localparam logic [1:0] POLICY_FIRST = 2'd0;
	localparam logic [1:0] POLICY_BEST  = 2'd1;
	localparam logic [1:0] POLICY_WORST = 2'd2;

	typedef struct packed {
		logic [1:0]           func;
		logic [INDEX_BITS-1:0] block_index;
		logic [SIZE_BITS-1:0]  size_value;
	} in_item_t;

	typedef struct packed {
		logic                  granted;
		logic [INDEX_BITS-1:0] granted_block;
		logic                  is_ack;
	} out_item_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_COMMIT
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic latch_item;
		logic scan_init;
		logic scan_step;
		logic commit;
	} ctrl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic item_alloc;
		logic scan_last;
	} dp_status_t;

endpackage

[rtl/core/fpba_datapath.sv]
`timescale 1ns / 1ps
// allocator datapath: config registers, block size memory, busy marks,
// scan counter and best candidate registers; depends on fpba_pkg
module fpba_datapath #(
	parameter int MAX_BLOCKS = fpba_pkg::DEF_MAX_BLOCKS
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  fpba_pkg::in_item_t                    in_item,
	input  logic                                  cfg_we,
	input  logic [fpba_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
	input  logic [fpba_pkg::CFG_DATA_BITS-1:0]    cfg_data,
	input  fpba_pkg::ctrl_cmd_t                   cmd,
	output fpba_pkg::dp_status_t                  status,
	output fpba_pkg::out_item_t                   out_item
);
	import fpba_pkg::*;

	localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
	localparam int CNT_W = $clog2(MAX_BLOCKS + 1);

	// configuration registers
	logic [1:0] fit_policy_q;
	logic [6:0] blk_cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fit_policy_q <= POLICY_FIRST;
			blk_cnt_q    <= BLOCK_COUNT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_FIT_POLICY:  fit_policy_q <= cfg_data[1:0];
				REG_BLOCK_COUNT: blk_cnt_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// held item
	logic [1:0]            func_q;
	logic [INDEX_BITS-1:0] idx_q;
	logic [SIZE_BITS-1:0]  size_q;

	always_ff @(posedge clk) begin
		if (cmd.latch_item) begin
			func_q <= in_item.func;
			idx_q  <= in_item.block_index;
			size_q <= in_item.size_value;
		end
	end

	// active block count, saturated to the memory depth
	logic [31:0]      cnt_ext;
	logic [CNT_W-1:0] active;

	always_comb begin
		cnt_ext = 32'(blk_cnt_q);
		active  = (cnt_ext > 32'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS) : CNT_W'(cnt_ext);
	end

	// scan issue counter
	logic [CNT_W-1:0] iss_q;
	logic             issue_more;
	logic [IDX_W-1:0] iss_addr;

	assign issue_more = (iss_q < active);
	assign iss_addr   = iss_q[IDX_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iss_q <= '0;
		end else if (cmd.scan_init) begin
			iss_q <= '0;
		end else if (cmd.scan_step && issue_more) begin
			iss_q <= iss_q + CNT_W'(1);
		end
	end

	// load target check
	logic             load_ok;
	logic [IDX_W-1:0] load_addr;

	assign load_ok   = (32'(idx_q) < 32'(MAX_BLOCKS));
	assign load_addr = IDX_W'(idx_q);

	// block size memory, one write and one registered read port
	logic [SIZE_BITS-1:0] size_mem [MAX_BLOCKS];
	logic [SIZE_BITS-1:0] rd_size_s1;
	logic [IDX_W-1:0]     rd_idx_s1;

	always_ff @(posedge clk) begin
		if (cmd.commit && (func_q == FUNC_LOAD) && load_ok) begin
			size_mem[load_addr] <= size_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan_step && issue_more) begin
			rd_size_s1 <= size_mem[iss_addr];
			rd_idx_s1  <= iss_addr;
		end
	end

	// busy marks
	logic [MAX_BLOCKS-1:0] busy_q;
	logic                  busy_s1;
	logic                  rd_vld_s1;

	always_ff @(posedge clk) begin
		if (cmd.scan_step && issue_more) begin
			busy_s1 <= busy_q[iss_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1 <= 1'b0;
		end else if (cmd.scan_init) begin
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= cmd.scan_step && issue_more;
		end
	end

	// best candidate so far
	logic                 pick_vld_q;
	logic [IDX_W-1:0]     pick_idx_q;
	logic [SIZE_BITS-1:0] pick_size_q;
	logic                 fits;
	logic                 better;

	always_comb begin
		fits = rd_vld_s1 && !busy_s1 && (rd_size_s1 >= size_q);
		priority if (!pick_vld_q) begin
			better = 1'b1;
		end else if (fit_policy_q == POLICY_BEST) begin
			better = (rd_size_s1 < pick_size_q);
		end else if (fit_policy_q == POLICY_WORST) begin
			better = (rd_size_s1 > pick_size_q);
		end else begin
			better = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pick_vld_q <= 1'b0;
		end else if (cmd.scan_init) begin
			pick_vld_q <= 1'b0;
		end else if (fits) begin
			pick_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (fits && better) begin
			pick_idx_q  <= rd_idx_s1;
			pick_size_q <= rd_size_s1;
		end
	end

	// busy update on commit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= '0;
		end else if (cmd.commit) begin
			if (func_q == FUNC_CLEAR) begin
				busy_q <= '0;
			end else if ((func_q == FUNC_ALLOC) && pick_vld_q) begin
				busy_q[pick_idx_q] <= 1'b1;
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			if (func_q == FUNC_ALLOC) begin
				out_item.granted       <= pick_vld_q;
				out_item.granted_block <= pick_vld_q ? INDEX_BITS'(pick_idx_q) : '0;
				out_item.is_ack        <= 1'b0;
			end else begin
				out_item.granted       <= 1'b0;
				out_item.granted_block <= '0;
				out_item.is_ack        <= 1'b1;
			end
		end
	end

	// status to controller
	assign status.item_alloc = (func_q == FUNC_ALLOC);
	assign status.scan_last  = !issue_more && !rd_vld_s1;

endmodule

[rtl/core/fpba_ctrl.sv]
`timescale 1ns / 1ps
// allocator controller: state machine sequencing accept, scan and commit,
// plus the result valid flag; depends on fpba_pkg
module fpba_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  logic                 out_ready,
	input  fpba_pkg::dp_status_t status,
	output fpba_pkg::ctrl_cmd_t  cmd
);
	import fpba_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   out_free;

	assign out_free = !out_valid || out_ready;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (!status.item_alloc || status.scan_last) state_d = ST_COMMIT;
			end
			ST_COMMIT: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		in_ready       = 1'b0;
		cmd.latch_item = 1'b0;
		cmd.scan_init  = 1'b0;
		cmd.scan_step  = 1'b0;
		cmd.commit     = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready       = 1'b1;
				cmd.latch_item = in_valid;
				cmd.scan_init  = in_valid;
			end
			ST_SCAN: begin
				cmd.scan_step = status.item_alloc;
			end
			ST_COMMIT: begin
				cmd.commit = out_free;
			end
			default: ;
		endcase
	end

	// result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.commit) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

endmodule

[rtl/core/fit_policy_block_allocator.sv]
`timescale 1ns / 1ps
// fixed-partition block allocator with first, best and worst fit policies
// load and clear pass from accept through scan straight to commit; allocate scans the
// active blocks in order, one block scanned per cycle, then commits
// a new item is accepted only after the previous one has committed; a commit
// stalls while the previous result still waits
// reset: async active low; busy marks clear, policy first fit, count 64
module fit_policy_block_allocator #(
	parameter int MAX_BLOCKS = fpba_pkg::DEF_MAX_BLOCKS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  fpba_pkg::in_item_t                  in_item,
	output logic                                out_valid,
	input  logic                                out_ready,
	output fpba_pkg::out_item_t                 out_item,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [fpba_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [fpba_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
	import fpba_pkg::*;

	ctrl_cmd_t  cmd;
	dp_status_t status;

	// config writes are always taken
	assign cfg_ready = 1'b1;

	fpba_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	fpba_datapath #(
		.MAX_BLOCKS (MAX_BLOCKS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_item   (in_item),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.status    (status),
		.out_item  (out_item)
	);

endmodule

[tb/sv/tb_fit_policy_block_allocator.sv]
`timescale 1ns / 1ps
// self-checking testbench for fit_policy_block_allocator: directed and random
// load, clear and allocate traffic under every fit policy; depends on fpba_pkg
module tb_fit_policy_block_allocator;
	import fpba_pkg::*;

	// codes the package leaves unnamed
	localparam logic [1:0] FUNC_NOP     = 2'd3;
	localparam logic [1:0] POLICY_UNDEF = 2'd3;

	// run limits for the cycle guard and the final drain
	localparam int CYCLE_LIMIT  = 1000000;
	localparam int DRAIN_CYCLES = 100;

	logic                      clk;
	logic                      arst_n;
	logic                      in_valid;
	logic                      in_ready;
	in_item_t                  in_item;
	logic                      out_valid;
	logic                      out_ready;
	out_item_t                 out_item;
	logic                      cfg_valid;
	logic                      cfg_ready;
	logic [CFG_INDEX_BITS-1:0] cfg_index;
	logic [CFG_DATA_BITS-1:0]  cfg_data;

	// predicted partition table and queue of expected results
	class alloc_scoreboard;
		logic [SIZE_BITS-1:0]      block_size [DEF_MAX_BLOCKS];
		bit                        block_busy [DEF_MAX_BLOCKS];
		bit                        size_loaded [DEF_MAX_BLOCKS];
		logic [1:0]                policy;
		logic [CFG_DATA_BITS-1:0]  count;
		out_item_t                 pending_grants [$];
		int                        errors;

		function new();
			for (int k = 0; k < DEF_MAX_BLOCKS; k++) begin
				block_size[k] = '0;
				block_busy[k] = 1'b0;
				size_loaded[k] = 1'b0;
			end
			policy = POLICY_FIRST;
			count = BLOCK_COUNT_RESET;
			errors = 0;
		endfunction

		function void set_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
			if (idx == REG_FIT_POLICY) begin
				policy = data[1:0];
			end else begin
				count = data;
			end
		endfunction

		// counts above the table size saturate
		function int active_blocks();
			return (count > DEF_MAX_BLOCKS) ? DEF_MAX_BLOCKS : int'(count);
		endfunction

		// lowest block in the scan range that was never loaded, -1 if none
		function int first_unloaded();
			int n;
			n = active_blocks();
			for (int k = 0; k < n; k++) begin
				if (!size_loaded[k])
					return k;
			end
			return -1;
		endfunction

		// block chosen for a request, -1 when nothing fits; ties keep the lower index
		function int predict_grant(logic [SIZE_BITS-1:0] want);
			int pick;
			int n;
			bit stop;
			pick = -1;
			stop = 1'b0;
			n = active_blocks();
			for (int k = 0; k < n && !stop; k++) begin
				if (!block_busy[k] && block_size[k] >= want) begin
					if (pick < 0) begin
						pick = k;
						stop = (policy != POLICY_BEST) && (policy != POLICY_WORST);
					end else if (policy == POLICY_BEST && block_size[k] < block_size[pick]) begin
						pick = k;
					end else if (policy == POLICY_WORST && block_size[k] > block_size[pick]) begin
						pick = k;
					end
				end
			end
			return pick;
		endfunction

		// update the table for an input transfer and queue its result
		function void note_item(in_item_t it);
			out_item_t res;
			int pick;
			res = '0;
			res.is_ack = 1'b1;
			case (it.func)
				FUNC_LOAD: begin
					block_size[it.block_index] = it.size_value;
					size_loaded[it.block_index] = 1'b1;
				end
				FUNC_CLEAR: begin
					for (int k = 0; k < DEF_MAX_BLOCKS; k++)
						block_busy[k] = 1'b0;
				end
				FUNC_ALLOC: begin
					pick = predict_grant(it.size_value);
					res.is_ack = 1'b0;
					if (pick >= 0) begin
						block_busy[pick] = 1'b1;
						res.granted = 1'b1;
						res.granted_block = pick[INDEX_BITS-1:0];
					end
				end
				default: ;
			endcase
			pending_grants.push_back(res);
		endfunction

		task report(string what);
			errors++;
			$display("mismatch at %0t: %s", $realtime, what);
		endtask

		// compare a result transfer with the oldest expectation
		task check_result(out_item_t got);
			out_item_t want;
			if (pending_grants.size() == 0) begin
				report($sformatf("result with nothing pending: granted %0b block %0d ack %0b",
					got.granted, got.granted_block, got.is_ack));
				return;
			end
			want = pending_grants.pop_front();
			if (got.is_ack !== want.is_ack)
				report($sformatf("is_ack %0b, expected %0b", got.is_ack, want.is_ack));
			if (got.granted !== want.granted)
				report($sformatf("granted %0b, expected %0b", got.granted, want.granted));
			if (got.granted_block !== want.granted_block)
				report($sformatf("granted_block %0d, expected %0d",
					got.granted_block, want.granted_block));
		endtask
	endclass

	alloc_scoreboard sb;
	int cycle_count = 0;
	int stall_left = 0;
	int calm_left = 0;
	bit calm = 1'b0;

	fit_policy_block_allocator DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// 8 ns clock
	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// run guard
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// result side back-pressure: calm stretches, short stalls and a few long ones
	always @(negedge clk) begin
		if (calm_left == 0) begin
			calm = ($urandom_range(0, 3) == 0);
			calm_left = $urandom_range(100, 400);
		end else begin
			calm_left--;
		end
		if (stall_left > 0) begin
			stall_left--;
		end else if (calm || $urandom_range(0, 99) < 55) begin
			out_ready <= 1'b1;
		end else begin
			out_ready <= 1'b0;
			stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
		end
	end

	// result transfers
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result(out_item);
	end

	function automatic in_item_t item_of(logic [1:0] f, logic [INDEX_BITS-1:0] b,
		logic [SIZE_BITS-1:0] s);
		in_item_t it;
		it.func = f;
		it.block_index = b;
		it.size_value = s;
		return it;
	endfunction

	// block sizes from a short list so that ties are common
	function automatic logic [SIZE_BITS-1:0] palette_size();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			2, 3: return 16'd1000;
			4: return 16'd4096;
			5: return 16'd250;
			default: return SIZE_BITS'($urandom);
		endcase
	endfunction

	// mostly allocates; an allocate that would scan an unloaded block loads it instead
	function automatic in_item_t random_item(int clear_pct);
		in_item_t it;
		int r;
		int k;
		int hole;
		it.func = FUNC_ALLOC;
		it.block_index = INDEX_BITS'($urandom);
		it.size_value = SIZE_BITS'($urandom);
		r = $urandom_range(0, 99);
		if (r < 4) begin
			it.func = FUNC_NOP;
		end else if (r < 4 + clear_pct) begin
			it.func = FUNC_CLEAR;
		end else if (r < 24 + clear_pct) begin
			it.func = FUNC_LOAD;
			it.size_value = palette_size();
		end else begin
			case ($urandom_range(0, 5))
				0: it.size_value = '0;
				1: it.size_value = '1;
				2: begin
					k = $urandom_range(0, DEF_MAX_BLOCKS - 1);
					it.size_value = SIZE_BITS'(int'(sb.block_size[k]) + $urandom_range(0, 2) - 1);
				end
				3: it.size_value = SIZE_BITS'($urandom_range(0, 1200));
				default: ;
			endcase
		end
		if (it.func == FUNC_ALLOC) begin
			hole = sb.first_unloaded();
			if (hole >= 0) begin
				it.func = FUNC_LOAD;
				it.block_index = hole[INDEX_BITS-1:0];
				it.size_value = palette_size();
			end
		end
		return it;
	endfunction

	// one input transfer after a random gap
	task automatic send_item(in_item_t it);
		int r;
		int gap;
		r = $urandom_range(0, 99);
		gap = (r < 65) ? 0 : (r < 95) ? $urandom_range(1, 3) : $urandom_range(8, 40);
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_item <= it;
		do @(posedge clk); while (!in_ready);
		sb.note_item(it);
	endtask

	task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		sb.set_reg(idx, data);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// drop valid and wait for every queued result
	task automatic wait_idle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.pending_grants.size() != 0)
			@(posedge clk);
	endtask

	// policy upper data bits are don't-care and get random values
	task automatic run_random(logic [1:0] pol, logic [CFG_DATA_BITS-1:0] cnt, int n, int clear_pct);
		wait_idle();
		write_reg(REG_FIT_POLICY, {5'($urandom), pol});
		write_reg(REG_BLOCK_COUNT, cnt);
		repeat (n) send_item(random_item(clear_pct));
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_item = '0;
		out_ready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_FIT_POLICY;
		cfg_data = '0;
		sb = new();
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// first fit on four blocks, with a tie between blocks 0 and 3
		write_reg(REG_FIT_POLICY, {5'd0, POLICY_FIRST});
		write_reg(REG_BLOCK_COUNT, 7'd4);
		send_item(item_of(FUNC_LOAD, 6'd0, 16'd1000));
		send_item(item_of(FUNC_LOAD, 6'd1, 16'hFFFF));
		send_item(item_of(FUNC_LOAD, 6'd2, 16'd500));
		send_item(item_of(FUNC_LOAD, 6'd3, 16'd1000));
		send_item(item_of(FUNC_ALLOC, 6'd63, 16'd0));
		send_item(item_of(FUNC_ALLOC, 6'd0, 16'hFFFF));
		send_item(item_of(FUNC_ALLOC, 6'd0, 16'd600));
		send_item(item_of(FUNC_ALLOC, 6'd0, 16'd1));
		// everything busy: even a zero request fails
		send_item(item_of(FUNC_ALLOC, 6'd0, 16'd0));
		send_item(item_of(FUNC_CLEAR, 6'd63, 16'hFFFF));
		// undefined function code is just acknowledged
		send_item(item_of(FUNC_NOP, 6'd63, 16'hFFFF));
		wait_idle();

		// best fit, tie goes to the lower index
		write_reg(REG_FIT_POLICY, {5'd0, POLICY_BEST});
		send_item(item_of(FUNC_ALLOC, 6'd0, 16'd600));
		send_item(item_of(FUNC_ALLOC, 6'd0, 16'd600));
		send_item(item_of(FUNC_ALLOC, 6'd0, 16'd0));
		send_item(item_of(FUNC_ALLOC, 6'd0, 16'd0));
		send_item(item_of(FUNC_CLEAR, 6'd0, 16'd0));
		wait_idle();

		// worst fit; a load does not free a busy block
		write_reg(REG_FIT_POLICY, {5'd0, POLICY_WORST});
		send_item(item_of(FUNC_ALLOC, 6'd0, 16'd0));
		send_item(item_of(FUNC_ALLOC, 6'd0, 16'd0));
		send_item(item_of(FUNC_ALLOC, 6'd0, 16'd0));
		send_item(item_of(FUNC_ALLOC, 6'd0, 16'd600));
		send_item(item_of(FUNC_LOAD, 6'd0, 16'd0));
		send_item(item_of(FUNC_ALLOC, 6'd0, 16'd0));
		send_item(item_of(FUNC_CLEAR, 6'd0, 16'd0));
		send_item(item_of(FUNC_ALLOC, 6'd0, 16'hFFFF));
		wait_idle();

		// zero blocks in use: every allocate fails
		write_reg(REG_BLOCK_COUNT, 7'd0);
		send_item(item_of(FUNC_ALLOC, 6'd0, 16'd0));

		// random phases over policies and block counts, extremes included
		run_random(POLICY_FIRST, 7'd64, 250, 3);
		run_random(POLICY_BEST, 7'd64, 250, 3);
		run_random(POLICY_WORST, 7'd64, 250, 3);
		run_random(POLICY_UNDEF, 7'd127, 200, 3);
		run_random(POLICY_BEST, 7'd1, 100, 10);
		run_random(POLICY_WORST, 7'd0, 60, 10);
		run_random(POLICY_FIRST, 7'd17, 150, 6);
		run_random(POLICY_BEST, 7'd100, 200, 3);
		run_random(POLICY_WORST, 7'd33, 150, 5);
		repeat (3)
			run_random(2'($urandom), 7'($urandom_range(1, 64)), 50, 6);

		// drain and watch for stray results
		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.pending_grants.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

[sim.f]
rtl/core/fpba_pkg.sv
rtl/core/fpba_datapath.sv
rtl/core/fpba_ctrl.sv
rtl/core/fit_policy_block_allocator.sv
tb/sv/tb_fit_policy_block_allocator.sv
